// File: src/wdsu_pkg.sv
// Shared types and constants of the windowed dropout shift unit.
package wdsu_pkg;

   localparam int RANGE_BITS  = 19;
   localparam int PUSH_BITS   = 16;
   localparam int FRAME_BITS  = 32;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int QUEUE_DEPTH = 4;
   localparam int ENV_BITS    = 18;
   localparam int COS_BITS    = 18;
   localparam int ONE16       = 65536;
   localparam int ENV_FULL    = 131072;

   // opcodes carried in req_tuser
   localparam logic OP_SHIFT    = 1'b0;
   localparam logic OP_CLASSIFY = 1'b1;

   // envelope handling of one queued entry
   typedef enum logic [1:0] {
      ENV_PASS = 2'd0,   // sample outside its run: no shift, no clamp
      ENV_FLAT = 2'd1,   // middle of the run: envelope is one
      ENV_RAMP = 2'd2    // cosine ramp at either end
   } env_mode_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_SIGNAL_RANGE = 3'd0,
      CSR_CLAMP_LOW    = 3'd1,
      CSR_CLAMP_HIGH   = 3'd2,
      CSR_ACTIVE_FIRST = 3'd3,
      CSR_ACTIVE_LAST  = 3'd4
   } csr_index_type;

   // front end status toward the queue and top level
   typedef struct packed {
      logic push;
      logic hold;
   } front_stat_type;

endpackage

// File: src/wdsu_queue.sv
// Small FIFO between the classifying front end and the datapath back end.
module wdsu_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data
);
   import wdsu_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);

   logic [WIDTH-1:0] mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PW:0]      count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == (PW+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: src/wdsu_front.sv
// Front end: accepts transactions, finds the envelope phase or splits runs into rows.
module wdsu_front #(
   parameter int ADDR_BITS   = 20,
   parameter int SAMPLE_BITS = 20,
   parameter int REQ_W       = 152,
   parameter int EW          = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic                      req_tuser,
   input  logic [REQ_W-1:0]          req_tdata,
   input  logic [ADDR_BITS-1:0]      active_first,
   input  logic [ADDR_BITS-1:0]      active_last,
   input  logic                      q_full,
   output logic [EW-1:0]             q_data,
   output wdsu_pkg::front_stat_type  stat
);
   import wdsu_pkg::*;

   localparam int AB = ADDR_BITS;
   localparam int SB = SAMPLE_BITS;

   typedef struct packed {
      logic                   is_row;
      env_mode_type           mode;
      logic signed [SB-1:0]   luma;
      logic signed [SB-1:0]   chroma;
      logic [PUSH_BITS-1:0]   push;
      logic                   up;
      logic [AB:0]            m;
      logic [AB:0]            n;
      logic [FRAME_BITS-1:0]  frame;
      logic [AB-1:0]          first;
      logic [AB:0]            len;
      logic                   vis;
      logic                   last;
   } entry_type;

   // input fields, lowest bits first
   logic signed [SB-1:0]  f_luma, f_chroma;
   logic [AB-1:0]         f_local, f_first;
   logic [AB:0]           f_len;
   logic [PUSH_BITS-1:0]  f_push;
   logic                  f_up;
   logic [FRAME_BITS-1:0] f_frame;

   assign f_luma   = req_tdata[SB-1:0];
   assign f_chroma = req_tdata[2*SB-1:SB];
   assign f_local  = req_tdata[2*SB+AB-1:2*SB];
   assign f_first  = req_tdata[2*SB+2*AB-1:2*SB+AB];
   assign f_len    = req_tdata[2*SB+3*AB:2*SB+2*AB];
   assign f_push   = req_tdata[2*SB+3*AB+PUSH_BITS:2*SB+3*AB+1];
   assign f_up     = req_tdata[2*SB+3*AB+PUSH_BITS+1];
   assign f_frame  = req_tdata[2*SB+3*AB+PUSH_BITS+FRAME_BITS+1:2*SB+3*AB+PUSH_BITS+2];

   entry_type cur, second, hold_data_ff, hold_data_in;
   logic      hold_ff, hold_in;
   logic      two_rows, no_rows, accept;

   // envelope phase of a sample
   logic [AB+2:0] p4, n3, n4, mirror;
   logic [AB+1:0] e_end, a_ext, b1_ext;

   always_comb begin
      p4     = {1'b0, f_local, 2'b10};
      n3     = (AB+3)'(f_len) + (AB+3)'({f_len, 1'b0});
      n4     = {f_len, 2'b00};
      mirror = n4 - p4;
      e_end  = (AB+2)'(f_first) + (AB+2)'(f_len);
      a_ext  = (AB+2)'(active_first);
      b1_ext = (AB+2)'(active_last) + 1'b1;
   end

   // build the first entry and the optional second row
   always_comb begin
      cur          = '0;
      second       = '0;
      two_rows     = 1'b0;
      no_rows      = 1'b0;
      cur.luma     = f_luma;
      cur.chroma   = f_chroma;
      cur.push     = f_push;
      cur.up       = f_up;
      cur.n        = f_len;
      cur.frame    = f_frame;
      cur.last     = 1'b1;
      second.is_row = 1'b1;
      second.frame = f_frame;
      second.last  = 1'b1;
      if (!req_tuser) begin
         if ((AB+1)'(f_local) >= f_len) begin
            cur.mode = ENV_PASS;
         end else if (p4 < (AB+3)'(f_len)) begin
            cur.mode = ENV_RAMP;
            cur.m    = p4[AB:0];
         end else if (p4 > n3) begin
            cur.mode = ENV_RAMP;
            cur.m    = mirror[AB:0];
         end else begin
            cur.mode = ENV_FLAT;
         end
      end else begin
         cur.is_row = 1'b1;
         cur.first  = f_first;
         cur.len    = f_len;
         if (f_len == '0) begin
            no_rows = 1'b1;
         end else if (e_end <= a_ext) begin
            cur.vis = 1'b0;
         end else if ((AB+2)'(f_first) >= a_ext && e_end <= b1_ext) begin
            cur.vis = 1'b1;
         end else if ((AB+2)'(f_first) >= b1_ext) begin
            cur.vis = 1'b0;
         end else if ((AB+2)'(f_first) < a_ext) begin
            two_rows     = 1'b1;
            cur.len      = (AB+1)'(a_ext - (AB+2)'(f_first));
            cur.last     = 1'b0;
            second.first = a_ext[AB-1:0];
            second.len   = (AB+1)'(e_end - a_ext);
            second.vis   = 1'b1;
         end else if (e_end > b1_ext) begin
            two_rows     = 1'b1;
            cur.len      = (AB+1)'(b1_ext - (AB+2)'(f_first));
            cur.vis      = 1'b1;
            cur.last     = 1'b0;
            second.first = b1_ext[AB-1:0];
            second.len   = (AB+1)'(e_end - b1_ext);
         end else begin
            cur.vis = 1'b0;
         end
      end
   end

   // handshake and the held second row
   always_comb begin
      req_tready   = !hold_ff && !q_full;
      accept       = req_tvalid && req_tready;
      stat.hold    = hold_ff;
      stat.push    = 1'b0;
      q_data       = cur;
      hold_in      = hold_ff;
      hold_data_in = hold_data_ff;
      if (hold_ff) begin
         q_data    = hold_data_ff;
         stat.push = !q_full;
         if (!q_full) begin
            hold_in = 1'b0;
         end
      end else if (accept) begin
         stat.push = !no_rows;
         if (two_rows) begin
            hold_in      = 1'b1;
            hold_data_in = second;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= 1'b0;
      end else begin
         hold_ff <= hold_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_data_ff <= hold_data_in;
   end

endmodule

// File: src/wdsu_back.sv
// Back end: table index divider, cosine table, shift multiply, clamp and output register.
module wdsu_back #(
   parameter int ADDR_BITS       = 20,
   parameter int SAMPLE_BITS     = 20,
   parameter int COS_TABLE_DEPTH = 1024,
   parameter int RSP_W           = 120,
   parameter int EW              = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                q_valid,
   input  logic [EW-1:0]                       q_data,
   output logic                                q_pop,
   input  logic [wdsu_pkg::RANGE_BITS-1:0]     range_cfg,
   input  logic [SAMPLE_BITS-1:0]              clamp_low,
   input  logic [SAMPLE_BITS-1:0]              clamp_high,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [RSP_W-1:0]                    rsp_tdata,
   output logic                                rsp_tlast
);
   import wdsu_pkg::*;

   localparam int AB     = ADDR_BITS;
   localparam int SB     = SAMPLE_BITS;
   localparam int TWO_D  = 2 * COS_TABLE_DEPTH;
   localparam int QB     = $clog2(COS_TABLE_DEPTH + 1);
   localparam int KB     = $clog2(COS_TABLE_DEPTH);
   localparam int DW     = AB + 2;
   localparam int NW     = AB + 1 + $clog2(TWO_D) + 2;
   localparam int PRW    = PUSH_BITS + RANGE_BITS;
   localparam int PDW    = PRW + ENV_BITS;
   localparam int MAGW   = PDW - 33 + 1;
   localparam int XW     = ((SB > MAGW) ? SB : MAGW) + 2;
   localparam longint unsigned PI_Q30 = 64'd3373259426;
   localparam longint          ONE30  = 64'sd1073741824;

   typedef struct packed {
      logic                   is_row;
      env_mode_type           mode;
      logic signed [SB-1:0]   luma;
      logic signed [SB-1:0]   chroma;
      logic [PUSH_BITS-1:0]   push;
      logic                   up;
      logic [AB:0]            m;
      logic [AB:0]            n;
      logic [FRAME_BITS-1:0]  frame;
      logic [AB-1:0]          first;
      logic [AB:0]            len;
      logic                   vis;
      logic                   last;
   } entry_type;

   // unsigned shift-subtract quotient, used only while building the table
   function automatic longint unsigned udiv64(input longint unsigned num,
                                              input longint unsigned dv);
      longint unsigned quo;
      longint unsigned rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= dv) begin
            rem    = rem - dv;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Taylor-series cosine in Q1.16, worked out at elaboration
   function automatic logic signed [COS_BITS-1:0] cos_val(input int kk);
      longint unsigned a;
      longint unsigned q;
      longint          x2;
      longint          h;
      longint          den;
      longint          prod;
      logic            neg;
      a   = udiv64(PI_Q30 * longint'(kk), 64'(COS_TABLE_DEPTH));
      neg = (2 * kk) > COS_TABLE_DEPTH;
      if (neg) begin
         a = PI_Q30 - a;
      end
      x2 = longint'((a * a) >> 30);
      h  = ONE30;
      for (int i = 0; i < 6; i++) begin
         case (i)
            0: den = 132;
            1: den = 90;
            2: den = 56;
            3: den = 30;
            4: den = 12;
            default: den = 2;
         endcase
         // quotient truncates toward zero
         prod = x2 * h;
         if (prod < 0) begin
            h = ONE30 + longint'(udiv64(-prod, den * ONE30));
         end else begin
            h = ONE30 - longint'(udiv64(prod, den * ONE30));
         end
      end
      if (h < 0) begin
         h = 0;
      end
      if (h > ONE30) begin
         h = ONE30;
      end
      q = (longint'(h) + 64'd8192) >> 14;
      return neg ? -COS_BITS'(q) : COS_BITS'(q);
   endfunction

   logic signed [COS_BITS-1:0] cos_rom [COS_TABLE_DEPTH];

   for (genvar g = 0; g < COS_TABLE_DEPTH; g++) begin : g_rom
      localparam logic signed [COS_BITS-1:0] COS_K = cos_val(g);
      assign cos_rom[g] = COS_K;
   end

   logic en;

   // divider pipeline: stage 0 loads, stage j resolves one quotient bit
   logic               dv_ff  [QB+1];
   entry_type          de_ff  [QB+1];
   logic [NW-1:0]      rem_ff [QB+1];
   logic [DW-1:0]      den_ff [QB+1];
   logic [QB-1:0]      qt_ff  [QB+1];
   logic [PRW-1:0]     pr_ff  [QB+1];
   logic [NW-1:0]      dsh    [QB+1];
   logic               ge     [QB+1];
   logic [NW-1:0]      rem_nx [QB+1];
   entry_type          q_entry;

   assign en      = !rsp_tvalid || rsp_tready;
   assign q_pop   = en && q_valid;
   assign q_entry = q_data;

   always_comb begin
      dsh[0]    = '0;
      ge[0]     = 1'b0;
      rem_nx[0] = '0;
      for (int j = 1; j <= QB; j++) begin
         dsh[j]    = NW'(den_ff[j-1]) << (QB - j);
         ge[j]     = rem_ff[j-1] >= dsh[j];
         rem_nx[j] = ge[j] ? rem_ff[j-1] - dsh[j] : rem_ff[j-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= QB; j++) begin
            dv_ff[j] <= 1'b0;
         end
      end else if (en) begin
         dv_ff[0] <= q_valid;
         for (int j = 1; j <= QB; j++) begin
            dv_ff[j] <= dv_ff[j-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         de_ff[0]  <= q_entry;
         rem_ff[0] <= NW'(q_entry.m) * NW'(TWO_D) + NW'(q_entry.n);
         den_ff[0] <= {q_entry.n, 1'b0};
         qt_ff[0]  <= '0;
         pr_ff[0]  <= PRW'(q_entry.push) * PRW'(range_cfg);
         for (int j = 1; j <= QB; j++) begin
            de_ff[j]  <= de_ff[j-1];
            rem_ff[j] <= rem_nx[j];
            den_ff[j] <= den_ff[j-1];
            qt_ff[j]  <= qt_ff[j-1] | (QB'(ge[j]) << (QB - j));
            pr_ff[j]  <= pr_ff[j-1];
         end
      end
   end

   // table lookup stage
   logic                       tv_ff;
   entry_type                  te_ff;
   logic signed [COS_BITS-1:0] cos_ff;
   logic [PRW-1:0]             tpr_ff;
   logic [KB-1:0]              k_idx;

   assign k_idx = (qt_ff[QB] > QB'(COS_TABLE_DEPTH - 1)) ? KB'(COS_TABLE_DEPTH - 1)
                                                         : qt_ff[QB][KB-1:0];

   // multiply stage
   logic                mv_ff;
   entry_type           me_ff;
   logic [PDW-1:0]      prod_ff;
   logic [ENV_BITS-1:0] env;

   assign env = (te_ff.mode == ENV_RAMP) ? ENV_BITS'(ONE16 - cos_ff) : ENV_BITS'(ENV_FULL);

   always_ff @(posedge clock) begin
      if (reset) begin
         tv_ff <= 1'b0;
         mv_ff <= 1'b0;
      end else if (en) begin
         tv_ff <= dv_ff[QB];
         mv_ff <= tv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         te_ff   <= de_ff[QB];
         cos_ff  <= cos_rom[k_idx];
         tpr_ff  <= pr_ff[QB];
         me_ff   <= te_ff;
         prod_ff <= PDW'(tpr_ff) * PDW'(env);
      end
   end

   // round, apply direction, clamp; samples outside their run pass unchanged, rows give zero
   logic [PDW:0]          rnd;
   logic [MAGW-1:0]       mag;
   logic signed [XW-1:0]  sh, y_sum, c_sum, lo_x, hi_x, y_cl, c_cl;
   logic signed [SB-1:0]  y_res, c_res;

   always_comb begin
      rnd   = (PDW+1)'(prod_ff) + ((PDW+1)'(1) << 32);
      mag   = MAGW'(rnd >> 33);
      sh    = XW'($signed({1'b0, mag}));
      if (!me_ff.up) begin
         sh = -sh;
      end
      lo_x  = XW'($signed(clamp_low));
      hi_x  = XW'($signed(clamp_high));
      y_sum = XW'(me_ff.luma) + sh;
      c_sum = XW'(me_ff.chroma) + sh;
      y_cl  = (y_sum < lo_x) ? lo_x : y_sum;
      y_cl  = (y_cl > hi_x) ? hi_x : y_cl;
      c_cl  = (c_sum < lo_x) ? lo_x : c_sum;
      c_cl  = (c_cl > hi_x) ? hi_x : c_cl;
      if (me_ff.is_row) begin
         y_res = '0;
         c_res = '0;
      end else if (me_ff.mode == ENV_PASS) begin
         y_res = me_ff.luma;
         c_res = me_ff.chroma;
      end else begin
         y_res = y_cl[SB-1:0];
         c_res = c_cl[SB-1:0];
      end
   end

   // output register
   logic                  ov_ff;
   logic [RSP_W-1:0]      od_ff, od_in;
   logic                  ol_ff;

   always_comb begin
      od_in = '0;
      od_in[2*SB-1:0] = {c_res, y_res};
      if (me_ff.is_row) begin
         od_in[2*SB+FRAME_BITS+2*AB+1:2*SB] = {me_ff.vis, me_ff.len, me_ff.first, me_ff.frame};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (en) begin
         ov_ff <= mv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         od_ff <= od_in;
         ol_ff <= me_ff.last;
      end
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = od_ff;
   assign rsp_tlast  = ol_ff;

endmodule

// File: src/windowed_dropout_shift_unit.sv
// Windowed dropout shift unit: top level with configuration registers.
// Path: queue, then the divider (a load stage and QB bit stages, where
//   QB = clog2(COS_TABLE_DEPTH + 1)), table lookup, multiply and output registers.
// Throughput: one shift transaction per cycle; the pipeline stalls only on response
//   backpressure; a two-row split blocks requests until its second row is pushed.
// Reset: synchronous, active high; clears valid state and loads register defaults.
module windowed_dropout_shift_unit #(
   parameter int ADDR_BITS       = 20,
   parameter int SAMPLE_BITS     = 20,
   parameter int COS_TABLE_DEPTH = 1024,
   localparam int REQ_RAW = 2*SAMPLE_BITS + 3*ADDR_BITS + 1 + 16 + 1 + 32,
   localparam int REQ_W   = ((REQ_RAW + 7) / 8) * 8,
   localparam int RSP_RAW = 2*SAMPLE_BITS + 32 + 2*ADDR_BITS + 1 + 1,
   localparam int RSP_W   = ((RSP_RAW + 7) / 8) * 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // luma_in, chroma_in, local_index, run_first, run_length, push_req, push_up,
   // frame_number
   input  logic [REQ_W-1:0]                     req_tdata,
   // opcode
   input  logic                                 req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // luma_out, chroma_out, row_frame, row_first, row_length, row_visible
   output logic [RSP_W-1:0]                     rsp_tdata,
   output logic                                 rsp_tlast,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [wdsu_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [wdsu_pkg::CSR_DATA_BITS-1:0]   csr_data
);
   import wdsu_pkg::*;

   localparam int AB = ADDR_BITS;
   localparam int SB = SAMPLE_BITS;
   localparam int EW = 1 + 2 + 2*SB + PUSH_BITS + 1 + 2*(AB+1) + FRAME_BITS + AB + (AB+1) + 2;

   // configuration registers
   logic [RANGE_BITS-1:0] range_ff;
   logic [SB-1:0]         clamp_low_ff, clamp_high_ff;
   logic [AB-1:0]         act_first_ff, act_last_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_ff      <= RANGE_BITS'(179200);
         clamp_low_ff  <= SB'(-76802);
         clamp_high_ff <= SB'(232564);
         act_first_ff  <= AB'(24970);
         act_last_ff   <= AB'(706404);
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_SIGNAL_RANGE: range_ff      <= csr_data[RANGE_BITS-1:0];
            CSR_CLAMP_LOW:    clamp_low_ff  <= csr_data[SB-1:0];
            CSR_CLAMP_HIGH:   clamp_high_ff <= csr_data[SB-1:0];
            CSR_ACTIVE_FIRST: act_first_ff  <= csr_data[AB-1:0];
            CSR_ACTIVE_LAST:  act_last_ff   <= csr_data[AB-1:0];
            default: ;
         endcase
      end
   end

   front_stat_type  fstat;
   logic [EW-1:0]   f_data, q_head;
   logic            q_full, q_valid, q_pop;

   wdsu_front #(
      .ADDR_BITS   (AB),
      .SAMPLE_BITS (SB),
      .REQ_W       (REQ_W),
      .EW          (EW)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tuser    (req_tuser),
      .req_tdata    (req_tdata),
      .active_first (act_first_ff),
      .active_last  (act_last_ff),
      .q_full       (q_full),
      .q_data       (f_data),
      .stat         (fstat)
   );

   wdsu_queue #(
      .WIDTH (EW)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (fstat.push),
      .push_data  (f_data),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_data  (q_head)
   );

   wdsu_back #(
      .ADDR_BITS       (AB),
      .SAMPLE_BITS     (SB),
      .COS_TABLE_DEPTH (COS_TABLE_DEPTH),
      .RSP_W           (RSP_W),
      .EW              (EW)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_data       (q_head),
      .q_pop        (q_pop),
      .range_cfg    (range_ff),
      .clamp_low    (clamp_low_ff),
      .clamp_high   (clamp_high_ff),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast)
   );

   // the front end never pushes into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      fstat.push |-> !q_full)
      else $error("push into full queue");

   // a pending second row blocks new transactions
   a_hold_blocks: assert property (@(posedge clock) disable iff (reset)
      fstat.hold |-> !req_tready)
      else $error("transaction accepted while a row is held");

   // a stalled response keeps its contents until taken
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("response changed while stalled");

endmodule
